// ===== rtl/rtbs_pkg.sv =====
// package for the record table bubble sort unit
// holds the record, beat and memory request types, operation, status and sort key codes
// no dependencies
`timescale 1ns / 1ps

package rtbs_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int ADDR_W      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int TALLY_W     = 7;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_COUNT  = 3'd3;
	localparam logic [2:0] OP_SORT   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] KEY_VERSION = 2'd0;
	localparam logic [1:0] KEY_SIZE    = 2'd1;
	localparam logic [1:0] KEY_SERIAL  = 2'd2;
	localparam logic [1:0] KEY_FLAGS   = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic        is_64bit;
		logic [31:0] file_size;
		logic        hidden_flag;
		logic        system_flag;
		logic [5:0]  position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  tally;
		logic        out_is_64bit;
		logic [31:0] out_size;
		logic [15:0] out_serial;
		logic        out_hidden;
		logic        out_system;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        wide;
		logic [31:0] size;
		logic [15:0] serial;
		logic        hid;
		logic        sys;
	} rec_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		rec_t              wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/rtbs_store.sv =====
// record memory: one write port, one read port with registered read data
// depends on rtbs_pkg
`timescale 1ns / 1ps

module rtbs_store (
	input  logic              clk,
	input  rtbs_pkg::mem_req_t req,
	output rtbs_pkg::rec_t    rdata
);
	import rtbs_pkg::*;

	rec_t mem_q [MAX_RECORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[req.raddr];
	end

endmodule

// ===== rtl/rtbs_cmp.sv =====
// order compare unit shared by every bubble step
// depends on rtbs_pkg
`timescale 1ns / 1ps

module rtbs_cmp (
	input  logic [1:0]     sort_key,
	input  rtbs_pkg::rec_t a,
	input  rtbs_pkg::rec_t b,
	output logic           swap
);
	import rtbs_pkg::*;

	always_comb begin
		unique case (sort_key)
			KEY_VERSION: swap = a.wide < b.wide;
			KEY_SIZE:    swap = a.size < b.size;
			KEY_SERIAL:  swap = a.serial > b.serial;
			KEY_FLAGS:   swap = {a.hid, a.sys} < {b.hid, b.sys};
			default:     swap = 1'b0;
		endcase
	end

endmodule

// ===== rtl/record_table_bubble_sort_unit.sv =====
// top level of the record table bubble sort unit: sequencer and table state
// depends on rtbs_pkg, rtbs_store, rtbs_cmp
`timescale 1ns / 1ps

// Usage
//   Command channel: item is taken at a clock edge with start high and busy low.
//   Config: cfg_we writes cfg_data into sort_key; write only while the unit is idle.
//   Results: each beat shows on result for one cycle with strobe high; the
//   receiver cannot stall, it must take every beat. result.last marks the end.
//   Append, clear and unused codes: one beat the cycle after the command, busy
//   stays low. Delete with a bad or final position is the same.
//   Delete elsewhere: each record above the position is moved down one place, then the beat.
//   Count: reads every record and tallies those with both hidden and system set, then the beat.
//   Sort: each bubble pass is a read/compare/write stream through the single
//   memory port pair; passes repeat until one makes no swap (up to n passes
//   for n records), then n beats follow in consecutive cycles. An empty table
//   gives one beat, status empty.
//   Reset (arst_n low) empties the table, zeroes the serial counter and the
//   sort key; the record memory itself is not cleared and needs no sweep.

module record_table_bubble_sort_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rtbs_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_data,
	output rtbs_pkg::out_item_t result,
	output logic                strobe
);
	import rtbs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEL   = 3'd1;
	localparam logic [2:0] S_CNT   = 3'd2;
	localparam logic [2:0] S_P_LD  = 3'd3;
	localparam logic [2:0] S_P_RUN = 3'd4;
	localparam logic [2:0] S_P_END = 3'd5;
	localparam logic [2:0] S_EM    = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [15:0]       serial_q, serial_d;
	logic              swapped_q, swapped_d;
	logic [1:0]        key_q;
	rec_t              carry_q, carry_d;
	out_item_t         res_q, res_d;
	logic              strobe_q, strobe_d;

	mem_req_t          req;
	rec_t              rdata;
	logic              swap;
	logic              accept;
	logic [CNT_W-1:0]  acc_next;
	logic [CNT_W-1:0]  idx_ext;

	function automatic out_item_t make_res(input logic [1:0] st, input logic [TALLY_W-1:0] tl,
			input rec_t r, input logic has_rec, input logic lst);
		out_item_t o;
		o.status       = st;
		o.tally        = tl;
		o.out_is_64bit = has_rec ? r.wide : 1'b0;
		o.out_size     = has_rec ? r.size : 32'd0;
		o.out_serial   = has_rec ? r.serial : 16'd0;
		o.out_hidden   = has_rec ? r.hid : 1'b0;
		o.out_system   = has_rec ? r.sys : 1'b0;
		o.last         = lst;
		return o;
	endfunction

	rtbs_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	rtbs_cmp u_cmp (
		.sort_key (key_q),
		.a        (carry_q),
		.b        (rdata),
		.swap     (swap)
	);

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign result   = res_q;
	assign strobe   = strobe_q;
	assign idx_ext  = CNT_W'(idx_q);
	assign acc_next = acc_q + CNT_W'(rdata.hid & rdata.sys);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		count_d   = count_q;
		serial_d  = serial_q;
		swapped_d = swapped_q;
		carry_d   = carry_q;
		res_d     = res_q;
		strobe_d  = 1'b0;
		req.we    = 1'b0;
		req.waddr = '0;
		req.wdata = carry_q;
		req.raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (item.operation)
						OP_APPEND: begin
							if (count_q >= CNT_W'(MAX_RECORDS)) begin
								res_d = make_res(ST_FULL, TALLY_W'(count_q), carry_q, 1'b0, 1'b1);
							end else begin
								req.we    = 1'b1;
								req.waddr = ADDR_W'(count_q);
								req.wdata = '{wide: item.is_64bit, size: item.file_size,
									serial: serial_q, hid: item.hidden_flag,
									sys: item.system_flag};
								count_d   = count_q + CNT_W'(1);
								serial_d  = serial_q + 16'd1;
								res_d = make_res(ST_OK, TALLY_W'(count_d), carry_q, 1'b0, 1'b1);
							end
							strobe_d = 1'b1;
						end
						OP_DELETE: begin
							if (TALLY_W'(item.position) >= TALLY_W'(count_q)) begin
								res_d = make_res(ST_BADPOS, TALLY_W'(count_q), carry_q, 1'b0,
									1'b1);
								strobe_d = 1'b1;
							end else if (TALLY_W'(item.position) + TALLY_W'(1)
									== TALLY_W'(count_q)) begin
								count_d  = count_q - CNT_W'(1);
								res_d = make_res(ST_OK, TALLY_W'(count_d), carry_q, 1'b0, 1'b1);
								strobe_d = 1'b1;
							end else begin
								req.raddr = ADDR_W'(item.position + 6'd1);
								idx_d     = ADDR_W'(item.position);
								state_d   = S_DEL;
							end
						end
						OP_CLEAR: begin
							count_d  = '0;
							res_d    = make_res(ST_OK, '0, carry_q, 1'b0, 1'b1);
							strobe_d = 1'b1;
						end
						OP_COUNT: begin
							if (count_q == '0) begin
								res_d    = make_res(ST_OK, '0, carry_q, 1'b0, 1'b1);
								strobe_d = 1'b1;
							end else begin
								idx_d   = '0;
								acc_d   = '0;
								state_d = S_CNT;
							end
						end
						OP_SORT: begin
							idx_d = '0;
							if (count_q == '0) begin
								res_d    = make_res(ST_EMPTY, '0, carry_q, 1'b0, 1'b1);
								strobe_d = 1'b1;
							end else if (count_q == CNT_W'(1)) begin
								state_d = S_EM;
							end else begin
								state_d = S_P_LD;
							end
						end
						default: begin
							res_d    = make_res(ST_OK, TALLY_W'(count_q), carry_q, 1'b0, 1'b1);
							strobe_d = 1'b1;
						end
					endcase
				end
			end
			S_DEL: begin
				// close the gap: move record idx+1 down to idx
				req.we    = 1'b1;
				req.waddr = idx_q;
				req.wdata = rdata;
				if (idx_ext + CNT_W'(2) == count_q) begin
					count_d  = count_q - CNT_W'(1);
					res_d    = make_res(ST_OK, TALLY_W'(count_d), carry_q, 1'b0, 1'b1);
					strobe_d = 1'b1;
					state_d  = S_IDLE;
				end else begin
					req.raddr = ADDR_W'(idx_ext + CNT_W'(2));
					idx_d     = idx_q + ADDR_W'(1);
				end
			end
			S_CNT: begin
				acc_d = acc_next;
				if (idx_ext + CNT_W'(1) == count_q) begin
					res_d    = make_res(ST_OK, TALLY_W'(acc_next), carry_q, 1'b0, 1'b1);
					strobe_d = 1'b1;
					state_d  = S_IDLE;
				end else begin
					req.raddr = idx_q + ADDR_W'(1);
					idx_d     = idx_q + ADDR_W'(1);
				end
			end
			S_P_LD: begin
				carry_d   = rdata;
				req.raddr = ADDR_W'(1);
				idx_d     = ADDR_W'(1);
				swapped_d = 1'b0;
				state_d   = S_P_RUN;
			end
			S_P_RUN: begin
				// carry holds the larger-ranked record bubbling right
				req.we    = 1'b1;
				req.waddr = idx_q - ADDR_W'(1);
				req.wdata = swap ? rdata : carry_q;
				carry_d   = swap ? carry_q : rdata;
				swapped_d = swapped_q | swap;
				if (idx_ext + CNT_W'(1) == count_q) begin
					state_d = S_P_END;
				end else begin
					req.raddr = idx_q + ADDR_W'(1);
					idx_d     = idx_q + ADDR_W'(1);
				end
			end
			S_P_END: begin
				req.we    = 1'b1;
				req.waddr = ADDR_W'(count_q - CNT_W'(1));
				req.wdata = carry_q;
				idx_d     = '0;
				state_d   = swapped_q ? S_P_LD : S_EM;
			end
			S_EM: begin
				strobe_d = 1'b1;
				if (idx_ext + CNT_W'(1) == count_q) begin
					res_d   = make_res(ST_OK, TALLY_W'(count_q), rdata, 1'b1, 1'b1);
					state_d = S_IDLE;
				end else begin
					res_d     = make_res(ST_OK, TALLY_W'(count_q), rdata, 1'b1, 1'b0);
					req.raddr = idx_q + ADDR_W'(1);
					idx_d     = idx_q + ADDR_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			acc_q     <= '0;
			count_q   <= '0;
			serial_q  <= '0;
			swapped_q <= 1'b0;
			strobe_q  <= 1'b0;
			key_q     <= KEY_VERSION;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			acc_q     <= acc_d;
			count_q   <= count_d;
			serial_q  <= serial_d;
			swapped_q <= swapped_d;
			strobe_q  <= strobe_d;
			if (cfg_we) begin
				key_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= carry_d;
		res_q   <= res_d;
	end

endmodule

// ===== rtl/rtbs_chk.sv =====
// port-level checker for the record table bubble sort unit, bound to the top level
// depends on rtbs_pkg and record_table_bubble_sort_unit
`timescale 1ns / 1ps

module rtbs_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rtbs_pkg::in_item_t  item,
	input logic                cfg_we,
	input logic [1:0]          cfg_data,
	input rtbs_pkg::out_item_t result,
	input logic                strobe
);
	import rtbs_pkg::*;

	// a sort keeps emitting beats back to back until last
	a_emit_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside a sort emission");

	// an accepted command either works on or answers with a single final beat
	a_accept_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || (strobe && result.last))
		else $error("accepted command left no trace");

	// the final beat comes with the unit free again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy on final beat");

	// a non-final beat belongs to a sort still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final beat while idle");

	// error and empty answers are single beats
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.last)
		else $error("error status on a non-final beat");

endmodule

bind record_table_bubble_sort_unit rtbs_chk u_rtbs_chk (.*);
